FILE: design/dlf_pkg.sv
// ----------------------------------------------------------------------------
// Diode ladder filter package
// Shared widths, fixed-point constants, control codes and the saturation
// helper used by the filter datapath and its multiply unit.
// ----------------------------------------------------------------------------
package dlf_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int FREQ_STEPS_DEF = 128;
    localparam int RES_STEPS_DEF  = 8;
    localparam int TAB_DEPTH      = 1024;
    localparam int TAB_AW         = 10;
    localparam int ENTRY_W        = 3 * COEF_BITS;
    localparam int POS_W          = 17;
    localparam int FRAC_W         = 16;
    localparam int OP_W           = 33;
    localparam int PROD_W         = 2 * OP_W;
    localparam int Q_W            = PROD_W - 24;
    localparam int ACC_W          = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [POS_W-1:0]        POS_ONE   = 17'd65536;
    localparam logic signed [31:0]      SQRT2_Q24 = 32'sd23726566;
    localparam logic [25:0]             ONE_Q24   = 26'd16777216;
    localparam logic signed [ACC_W-1:0] S32_MAX   = 48'sd2147483647;
    localparam logic signed [ACC_W-1:0] S32_MIN   = -48'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Q_POSITION   = 3'd0,
        CFG_SHAPER_CUBIC = 3'd1,
        CFG_FB_HP_POLE   = 3'd2,
        CFG_DC_POLE      = 3'd3,
        CFG_NOTCH_B0     = 3'd4,
        CFG_NOTCH_B1     = 3'd5,
        CFG_NOTCH_A1     = 3'd6,
        CFG_NOTCH_A2     = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TABLE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_FETCH,
        FSM_CALC
    } fsm_t;

    typedef enum logic [5:0] {
        ST_LC0, ST_LC1, ST_LC2,
        ST_LF0, ST_LF1, ST_LF2,
        ST_LG0, ST_LG1, ST_LG2,
        ST_CLAMP, ST_CL1, ST_CL2, ST_CL3, ST_CL4,
        ST_FH1, ST_FH2, ST_FH3,
        ST_LD0, ST_LD1, ST_LK0, ST_LD2, ST_LK1, ST_LD3, ST_LK2, ST_LD4, ST_LK3,
        ST_GN,
        ST_DC1, ST_DC2, ST_DC3,
        ST_NT1, ST_NT2, ST_NT3, ST_NT4, ST_NT5,
        ST_OUT
    } step_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               hit;
    } sat_t;

    function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
        sat_t r;
        if (v > S32_MAX) begin
            r.val = 32'sh7fffffff;
            r.hit = 1'b1;
        end else if (v < S32_MIN) begin
            r.val = 32'sh80000000;
            r.hit = 1'b1;
        end else begin
            r.val = v[31:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

    // true for the steps that go through the shared multiplier
    function automatic logic has_mul(input step_t s);
        logic m;
        unique case (s) inside
            ST_CLAMP, ST_LD0, ST_LD1, ST_LD2, ST_LD3, ST_LD4, ST_OUT: m = 1'b0;
            default: m = 1'b1;
        endcase
        return m;
    endfunction

endpackage

FILE: design/diode_ladder_filter.sv
// ----------------------------------------------------------------------------
// Diode ladder filter
// Four-pole diode ladder with table-driven coefficients, soft-clipped
// feedback through a highpass, DC block and notch, in Q8.24 fixed point.
// ----------------------------------------------------------------------------
// A table-write transaction (opcode 1) writes one entry and produces no
// result. A sample transaction (opcode 0) first fetches the four neighboring
// table entries over the single RAM read port, then runs 29 products through
// the one shared multiplier plus seven add/saturate steps. s_ready is low
// while a sample is in work. The result register holds one finished sample,
// so the next transaction is taken while m_valid waits; a second result
// waits at the last step until the first is taken. Every table entry that a
// sample touches must be written before; the positions used are those of
// the accepted transaction and of q_position at that time. Configuration
// writes are taken at any time and should be made only while the filter is
// idle.
// ----------------------------------------------------------------------------
module diode_ladder_filter #(
    parameter int FREQ_STEPS = dlf_pkg::FREQ_STEPS_DEF,
    parameter int RES_STEPS  = dlf_pkg::RES_STEPS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_opcode,
    input  logic signed [dlf_pkg::SAMPLE_BITS-1:0] s_sample_in,
    input  logic signed [17:0]                     s_freq_position,
    input  logic signed [17:0]                     s_freq_mod,
    input  logic [dlf_pkg::TAB_AW-1:0]             s_entry_index,
    input  logic signed [dlf_pkg::COEF_BITS-1:0]   s_entry_cutoff,
    input  logic signed [dlf_pkg::COEF_BITS-1:0]   s_entry_feedback,
    input  logic signed [dlf_pkg::COEF_BITS-1:0]   s_entry_gain,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [dlf_pkg::SAMPLE_BITS-1:0] m_sample_out,
    output logic                                   m_saturated,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dlf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [dlf_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import dlf_pkg::*;

    localparam int FIDX_W = $clog2(FREQ_STEPS);
    localparam int RIDX_W = $clog2(RES_STEPS);
    localparam int FPOS_W = POS_W + FIDX_W;
    localparam int RPOS_W = POS_W + RIDX_W;
    localparam logic signed [31:0] OUT_MAX = 32'sd8388607;
    localparam logic signed [31:0] OUT_MIN = -32'sd8388608;

    typedef enum logic [1:0] {SEL_CUT, SEL_FB, SEL_GAIN} coef_sel_t;

    // configuration
    logic [POS_W-1:0]   q_position_reg;
    logic [24:0]        shaper_cubic_reg;
    logic [24:0]        fb_pole_reg;
    logic [24:0]        dc_pole_reg;
    logic signed [31:0] notch_b0_reg, notch_b1_reg, notch_a1_reg, notch_a2_reg;

    // control
    fsm_t        fsm_reg, fsm_next;
    step_t       step_reg;
    logic        phase_reg;
    logic [2:0]  fetch_cnt_reg;
    logic        act, out_free, s_accept, sample_accept;

    // lookup positions
    logic [FIDX_W-1:0] f0_reg, f1_reg;
    logic [RIDX_W-1:0] r0_reg, r1_reg;
    logic [FRAC_W-1:0] tf_reg, tq_reg;
    logic signed [18:0] fsum;
    logic [POS_W-1:0]  fclamp, qclamp;
    logic [FPOS_W-1:0] fpos;
    logic [RPOS_W-1:0] qpos;
    logic [FIDX_W-1:0] f0_raw, f0_sel, f1_sel;
    logic [RIDX_W-1:0] r0_raw, r0_sel, r1_sel;
    logic [FRAC_W-1:0] tf_sel, tq_sel;

    // table
    logic [TAB_AW-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] ent_reg [4];

    // datapath
    logic signed [31:0]    xin_reg;
    logic signed [31:0]    lo_reg, hi_reg, cut_reg, fbk_reg, gain_reg;
    logic signed [31:0]    yc_reg, hpin_reg, d_reg, v_reg;
    logic signed [OP_W-1:0] t_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]    s_reg [4];
    logic signed [31:0]    fb_px_reg, fb_py_reg, dc_px_reg, dc_py_reg;
    logic signed [31:0]    nh_reg [4];
    logic                  sat_reg;
    logic                  m_valid_reg, m_saturated_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_out_reg;

    coef_sel_t             coef_sel;
    logic signed [31:0]    e_lo_a, e_lo_b, e_hi_a, e_hi_b;
    logic signed [OP_W-1:0] op_a, op_b;
    logic signed [Q_W-1:0] prod_q24;
    logic [31:0]           prod_frac;
    logic signed [ACC_W-1:0] q_w, sat_in;
    sat_t                  sres;
    logic [25:0]           fb_gain_sum, dc_gain_sum;
    logic [24:0]           fb_gain, dc_gain;
    logic signed [32:0]    out_round;
    logic signed [31:0]    out_half;

    function automatic logic signed [ACC_W-1:0] w32(input logic signed [31:0] v);
        return {{(ACC_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [OP_W-1:0] sx(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [OP_W-1:0] zx(input logic [24:0] v);
        return {{(OP_W-25){1'b0}}, v};
    endfunction

    function automatic logic signed [31:0] fld(input logic [ENTRY_W-1:0] e,
                                               input coef_sel_t k);
        logic signed [31:0] r;
        unique case (k)
            SEL_CUT:  r = e[31:0];
            SEL_FB:   r = e[63:32];
            SEL_GAIN: r = e[95:64];
            default:  r = e[31:0];
        endcase
        return r;
    endfunction

    function automatic logic [TAB_AW-1:0] tab_addr(input logic [RIDX_W-1:0] r,
                                                   input logic [FIDX_W-1:0] f);
        logic [31:0] lin;
        lin = 32'(r) * 32'(FREQ_STEPS) + 32'(f);
        return lin[TAB_AW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_position_reg   <= 17'd13107;
            shaper_cubic_reg <= 25'd2796203;
            fb_pole_reg      <= 25'd16450983;
            dc_pole_reg      <= 25'd16746480;
            notch_b0_reg     <= 32'sd16736766;
            notch_b1_reg     <= -32'sd33473530;
            notch_a1_reg     <= 32'sd33473880;
            notch_a2_reg     <= -32'sd16696315;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_Q_POSITION:   q_position_reg   <= cfg_data[POS_W-1:0];
                CFG_SHAPER_CUBIC: shaper_cubic_reg <= cfg_data[24:0];
                CFG_FB_HP_POLE:   fb_pole_reg      <= cfg_data[24:0];
                CFG_DC_POLE:      dc_pole_reg      <= cfg_data[24:0];
                CFG_NOTCH_B0:     notch_b0_reg     <= cfg_data;
                CFG_NOTCH_B1:     notch_b1_reg     <= cfg_data;
                CFG_NOTCH_A1:     notch_a1_reg     <= cfg_data;
                CFG_NOTCH_A2:     notch_a2_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign fb_gain_sum = ONE_Q24 + 26'(fb_pole_reg);
    assign dc_gain_sum = ONE_Q24 + 26'(dc_pole_reg);
    assign fb_gain     = fb_gain_sum[25:1];
    assign dc_gain     = dc_gain_sum[25:1];

    // ------------------------------------------------------------------
    // Lookup position from the incoming transaction
    // ------------------------------------------------------------------
    always_comb begin
        fsum = {s_freq_position[17], s_freq_position} + {s_freq_mod[17], s_freq_mod};
        if (fsum[18]) begin
            fclamp = '0;
        end else if (fsum > 19'sd65536) begin
            fclamp = POS_ONE;
        end else begin
            fclamp = fsum[POS_W-1:0];
        end
        qclamp = (q_position_reg > POS_ONE) ? POS_ONE : q_position_reg;

        fpos   = FPOS_W'(fclamp) * FPOS_W'(FREQ_STEPS - 1);
        qpos   = RPOS_W'(qclamp) * RPOS_W'(RES_STEPS - 1);
        f0_raw = fpos[FRAC_W +: FIDX_W];
        r0_raw = qpos[FRAC_W +: RIDX_W];

        // clamp to the last step, zero weight
        if (f0_raw >= FIDX_W'(FREQ_STEPS - 1)) begin
            f0_sel = FIDX_W'(FREQ_STEPS - 1);
            f1_sel = FIDX_W'(FREQ_STEPS - 1);
            tf_sel = '0;
        end else begin
            f0_sel = f0_raw;
            f1_sel = f0_raw + 1'b1;
            tf_sel = fpos[FRAC_W-1:0];
        end
        if (r0_raw >= RIDX_W'(RES_STEPS - 1)) begin
            r0_sel = RIDX_W'(RES_STEPS - 1);
            r1_sel = RIDX_W'(RES_STEPS - 1);
            tq_sel = '0;
        end else begin
            r0_sel = r0_raw;
            r1_sel = r0_raw + 1'b1;
            tq_sel = qpos[FRAC_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign s_accept      = s_valid && s_ready;
    assign sample_accept = s_accept && (opcode_t'(s_opcode) == OP_SAMPLE);
    assign out_free      = !m_valid_reg || m_ready;
    assign act           = (fsm_reg == FSM_CALC) && (has_mul(step_reg) ? phase_reg : 1'b1);

    always_comb begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FSM_IDLE:  if (sample_accept) fsm_next = FSM_FETCH;
            FSM_FETCH: if (fetch_cnt_reg == 3'd4) fsm_next = FSM_CALC;
            FSM_CALC:  if (act && step_reg == ST_OUT && out_free) fsm_next = FSM_IDLE;
            default:   fsm_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (fsm_reg == FSM_IDLE);
        unique case (fetch_cnt_reg[1:0])
            2'd0:    rd_addr = tab_addr(r0_reg, f0_reg);
            2'd1:    rd_addr = tab_addr(r0_reg, f1_reg);
            2'd2:    rd_addr = tab_addr(r1_reg, f0_reg);
            default: rd_addr = tab_addr(r1_reg, f1_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg       <= FSM_IDLE;
            step_reg      <= ST_LC0;
            phase_reg     <= 1'b0;
            fetch_cnt_reg <= '0;
        end else begin
            fsm_reg <= fsm_next;
            if (fsm_reg == FSM_FETCH) begin
                fetch_cnt_reg <= fetch_cnt_reg + 1'b1;
            end else begin
                fetch_cnt_reg <= '0;
            end
            if (fsm_reg == FSM_CALC) begin
                if (has_mul(step_reg) && !phase_reg) begin
                    phase_reg <= 1'b1;
                end else if (step_reg == ST_OUT) begin
                    if (out_free) begin
                        step_reg <= ST_LC0;
                    end
                end else begin
                    phase_reg <= 1'b0;
                    step_reg  <= step_t'(step_reg + 6'd1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Coefficient table
    // ------------------------------------------------------------------
    dlf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TAB_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (s_accept && (opcode_t'(s_opcode) == OP_TABLE)),
        .wr_addr (s_entry_index),
        .wr_data ({s_entry_gain, s_entry_feedback, s_entry_cutoff}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (sample_accept) begin
            f0_reg  <= f0_sel;
            f1_reg  <= f1_sel;
            r0_reg  <= r0_sel;
            r1_reg  <= r1_sel;
            tf_reg  <= tf_sel;
            tq_reg  <= tq_sel;
            xin_reg <= {{(32-SAMPLE_BITS-1){s_sample_in[SAMPLE_BITS-1]}}, s_sample_in, 1'b0};
        end
        if (fsm_reg == FSM_FETCH && fetch_cnt_reg != 3'd0) begin
            ent_reg[fetch_cnt_reg[1:0] - 2'd1] <= rd_data;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier operands
    // ------------------------------------------------------------------
    always_comb begin
        unique case (step_reg) inside
            ST_LF0, ST_LF1, ST_LF2: coef_sel = SEL_FB;
            ST_LG0, ST_LG1, ST_LG2: coef_sel = SEL_GAIN;
            default:                coef_sel = SEL_CUT;
        endcase
        e_lo_a = fld(ent_reg[0], coef_sel);
        e_lo_b = fld(ent_reg[1], coef_sel);
        e_hi_a = fld(ent_reg[2], coef_sel);
        e_hi_b = fld(ent_reg[3], coef_sel);

        op_a = '0;
        op_b = '0;
        unique case (step_reg) inside
            ST_LC0, ST_LF0, ST_LG0: begin
                op_a = sx(e_lo_b) - sx(e_lo_a);
                op_b = OP_W'(tf_reg);
            end
            ST_LC1, ST_LF1, ST_LG1: begin
                op_a = sx(e_hi_b) - sx(e_hi_a);
                op_b = OP_W'(tf_reg);
            end
            ST_LC2, ST_LF2, ST_LG2: begin
                op_a = sx(hi_reg) - sx(lo_reg);
                op_b = OP_W'(tq_reg);
            end
            ST_CL1: begin op_a = sx(yc_reg);            op_b = sx(yc_reg);    end
            ST_CL2: begin op_a = t_reg;                 op_b = sx(yc_reg);    end
            ST_CL3: begin op_a = zx(shaper_cubic_reg);  op_b = t_reg;         end
            ST_CL4: begin op_a = sx(fbk_reg);           op_b = t_reg;         end
            ST_FH1: begin op_a = zx(fb_gain);           op_b = sx(hpin_reg);  end
            ST_FH2: begin op_a = zx(fb_gain);           op_b = sx(fb_px_reg); end
            ST_FH3: begin op_a = zx(fb_pole_reg);       op_b = sx(fb_py_reg); end
            ST_LK0, ST_LK1, ST_LK2, ST_LK3: begin
                op_a = sx(cut_reg);
                op_b = sx(d_reg);
            end
            ST_GN:  begin op_a = sx(gain_reg);          op_b = sx(s_reg[3]);  end
            ST_DC1: begin op_a = zx(dc_gain);           op_b = sx(v_reg);     end
            ST_DC2: begin op_a = zx(dc_gain);           op_b = sx(dc_px_reg); end
            ST_DC3: begin op_a = zx(dc_pole_reg);       op_b = sx(dc_py_reg); end
            ST_NT1: begin op_a = sx(notch_b0_reg);      op_b = sx(dc_py_reg); end
            ST_NT2: begin op_a = sx(notch_b1_reg);      op_b = sx(nh_reg[0]); end
            ST_NT3: begin op_a = sx(notch_b0_reg);      op_b = sx(nh_reg[1]); end
            ST_NT4: begin op_a = sx(notch_a1_reg);      op_b = sx(nh_reg[2]); end
            ST_NT5: begin op_a = sx(notch_a2_reg);      op_b = sx(nh_reg[3]); end
            default: ;
        endcase
    end

    dlf_mul u_mul (
        .aclk      (aclk),
        .op_a      (op_a),
        .op_b      (op_b),
        .prod_q24  (prod_q24),
        .prod_frac (prod_frac)
    );

    // ------------------------------------------------------------------
    // Add and saturate
    // ------------------------------------------------------------------
    always_comb begin
        q_w = {{(ACC_W-Q_W){prod_q24[Q_W-1]}}, prod_q24};
        unique case (step_reg) inside
            ST_CL4:                 sat_in = q_w;
            ST_FH3, ST_DC3, ST_NT5: sat_in = acc_reg + q_w;
            ST_LD0:                 sat_in = -w32(xin_reg) - w32(fb_py_reg);
            ST_LD1:                 sat_in = w32(d_reg) - w32(s_reg[0]) + w32(s_reg[1]);
            ST_LK0:                 sat_in = w32(s_reg[0]) + (q_w <<< 1);
            ST_LD2: sat_in = w32(s_reg[0]) - (w32(s_reg[1]) <<< 1) + w32(s_reg[2]);
            ST_LK1:                 sat_in = w32(s_reg[1]) + q_w;
            ST_LD3: sat_in = w32(s_reg[1]) - (w32(s_reg[2]) <<< 1) + w32(s_reg[3]);
            ST_LK2:                 sat_in = w32(s_reg[2]) + q_w;
            ST_LD4:                 sat_in = w32(s_reg[2]) - (w32(s_reg[3]) <<< 1);
            ST_LK3:                 sat_in = w32(s_reg[3]) + q_w;
            ST_GN:                  sat_in = q_w <<< 1;
            default:                sat_in = '0;
        endcase
        sres = sat32(sat_in);

        out_round = {nh_reg[2][31], nh_reg[2]} + 33'sd1;
        out_half  = out_round[32:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                s_reg[i]  <= '0;
                nh_reg[i] <= '0;
            end
            fb_px_reg <= '0;
            fb_py_reg <= '0;
            dc_px_reg <= '0;
            dc_py_reg <= '0;
            sat_reg   <= 1'b0;
        end else begin
            if (sample_accept) begin
                sat_reg <= 1'b0;
            end else if (act) begin
                sat_reg <= sat_reg | sres.hit;
            end
            if (act) begin
                unique case (step_reg) inside
                    ST_FH3: begin
                        fb_py_reg <= sres.val;
                        fb_px_reg <= hpin_reg;
                    end
                    ST_LK0: s_reg[0] <= sres.val;
                    ST_LK1: s_reg[1] <= sres.val;
                    ST_LK2: s_reg[2] <= sres.val;
                    ST_LK3: s_reg[3] <= sres.val;
                    ST_DC3: begin
                        dc_py_reg <= sres.val;
                        dc_px_reg <= v_reg;
                    end
                    ST_NT5: begin
                        nh_reg[2] <= sres.val;
                        nh_reg[3] <= nh_reg[2];
                        nh_reg[0] <= dc_py_reg;
                        nh_reg[1] <= nh_reg[0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (act) begin
            unique case (step_reg) inside
                ST_LC0, ST_LF0, ST_LG0: lo_reg <= e_lo_a + prod_frac;
                ST_LC1, ST_LF1, ST_LG1: hi_reg <= e_hi_a + prod_frac;
                ST_LC2: cut_reg  <= lo_reg + prod_frac;
                ST_LF2: fbk_reg  <= lo_reg + prod_frac;
                ST_LG2: gain_reg <= lo_reg + prod_frac;
                ST_CLAMP: begin
                    if (s_reg[3] > SQRT2_Q24) begin
                        yc_reg <= SQRT2_Q24;
                    end else if (s_reg[3] < -SQRT2_Q24) begin
                        yc_reg <= -SQRT2_Q24;
                    end else begin
                        yc_reg <= s_reg[3];
                    end
                end
                ST_CL1, ST_CL2: t_reg <= prod_q24[OP_W-1:0];
                ST_CL3: t_reg <= sx(yc_reg) - prod_q24[OP_W-1:0];
                ST_CL4: hpin_reg <= sres.val;
                ST_FH1, ST_DC1, ST_NT1: acc_reg <= q_w;
                ST_FH2, ST_DC2: acc_reg <= acc_reg - q_w;
                ST_NT2, ST_NT3, ST_NT4: acc_reg <= acc_reg + q_w;
                ST_LD0, ST_LD1, ST_LD2, ST_LD3, ST_LD4: d_reg <= sres.val;
                ST_GN: v_reg <= sres.val;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (act && step_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (act && step_reg == ST_OUT && out_free) begin
            if (out_half > OUT_MAX) begin
                m_sample_out_reg <= OUT_MAX[SAMPLE_BITS-1:0];
                m_saturated_reg  <= 1'b1;
            end else if (out_half < OUT_MIN) begin
                m_sample_out_reg <= OUT_MIN[SAMPLE_BITS-1:0];
                m_saturated_reg  <= 1'b1;
            end else begin
                m_sample_out_reg <= out_half[SAMPLE_BITS-1:0];
                m_saturated_reg  <= sat_reg;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;
    assign m_saturated  = m_saturated_reg;

endmodule

FILE: design/dlf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dlf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/dlf_mul.sv
// ----------------------------------------------------------------------------
// Shared multiply unit
// Registered signed 33x33 product, given both as a Q8.24 product rounded
// half up and as the low 32 bits of the product shifted right by 16.
// ----------------------------------------------------------------------------
module dlf_mul (
    input  logic                             aclk,
    input  logic signed [dlf_pkg::OP_W-1:0]  op_a,
    input  logic signed [dlf_pkg::OP_W-1:0]  op_b,
    output logic signed [dlf_pkg::Q_W-1:0]   prod_q24,
    output logic [31:0]                      prod_frac
);
    import dlf_pkg::*;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(24'h800000);

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [Q_W-1:0]    q24_reg;
    logic [31:0]              frac_reg;

    assign prod     = op_a * op_b;
    assign prod_rnd = prod + RND_HALF;

    always_ff @(posedge aclk) begin
        q24_reg  <= prod_rnd[PROD_W-1:24];
        frac_reg <= prod[FRAC_W+31:FRAC_W];
    end

    assign prod_q24  = q24_reg;
    assign prod_frac = frac_reg;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Diode ladder filter testbench
// Loads the coefficient table, then sends directed and random sample and
// table-write transactions under several register settings. A fixed-point
// filter predictor computes each output sample, and results are compared
// in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import dlf_pkg::*;

    typedef struct {
        opcode_t            op;
        logic signed [23:0] smp;
        logic signed [17:0] fpos;
        logic signed [17:0] fmod;
        logic [9:0]         idx;
        logic [31:0]        cut;
        logic [31:0]        fb;
        logic [31:0]        gain;
    } filt_item_t;

    typedef struct {
        logic signed [23:0] smp;
        logic               sat;
    } filt_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_opcode = 1'b0;
    logic signed [23:0] s_sample_in = '0;
    logic signed [17:0] s_freq_position = '0;
    logic signed [17:0] s_freq_mod = '0;
    logic [9:0] s_entry_index = '0;
    logic signed [31:0] s_entry_cutoff = '0;
    logic signed [31:0] s_entry_feedback = '0;
    logic signed [31:0] s_entry_gain = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [23:0] m_sample_out;
    logic m_saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    diode_ladder_filter u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_sample_in(s_sample_in), .s_freq_position(s_freq_position),
        .s_freq_mod(s_freq_mod), .s_entry_index(s_entry_index),
        .s_entry_cutoff(s_entry_cutoff), .s_entry_feedback(s_entry_feedback),
        .s_entry_gain(s_entry_gain),
        .m_valid(m_valid), .m_ready(m_ready), .m_sample_out(m_sample_out),
        .m_saturated(m_saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // filter predictor state and registers
    longint q_pos, cubic, fb_pole, dc_pole, nb0, nb1, na1, na2;
    int     ladder[4];
    int     fbhp_x, fbhp_y, dc_x, dc_y;
    int     notch_hist[4];
    int     tab_cut[1024], tab_fb[1024], tab_gain[1024];
    bit     sat_seen;

    filt_item_t pending_items[$];
    filt_out_t  expected_samples[$];
    int  mismatches = 0;
    int  samples_checked = 0;
    int  table_writes = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  s_fire = 1'b0;
    int  send_gap = 0;
    int  stall_cnt = 0;

    function automatic longint mulq(longint a, longint b);
        return (a * b + 64'sd8388608) >>> 24;
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1'b1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic int lerp(int a, int b, longint t);
        return int'(longint'(a) + (((longint'(b) - a) * t) >>> 16));
    endfunction

    function automatic longint clamp_unit(longint p);
        return p < 0 ? 0 : (p > 65536 ? 65536 : p);
    endfunction

    function automatic int one_pole_hp(longint pole, int x, ref int px, ref int py);
        longint b;
        int y;
        b = (64'sd16777216 + pole) >>> 1;
        y = sat32(mulq(b, x) - mulq(b, px) + mulq(pole, py));
        px = x;
        py = y;
        return y;
    endfunction

    function automatic longint bilerp(ref int t[1024], input int i00, input int i01,
                                      input int i10, input int i11,
                                      input longint tf, input longint tq);
        return lerp(lerp(t[i00], t[i01], tf), lerp(t[i10], t[i11], tf), tq);
    endfunction

    function automatic filt_out_t filter_sample(filt_item_t it);
        filt_out_t r;
        longint fp, qp, tf, tq, y, hpin, d;
        int f0, f1, r0, r1, i00, i01, i10, i11;
        int cut, fbg, gn, v, fbh, y0, dcout;
        sat_seen = 1'b0;
        fp = clamp_unit(longint'(it.fpos) + longint'(it.fmod)) * 127;
        qp = clamp_unit(q_pos) * 7;
        f0 = int'(fp >> 16); tf = fp & 16'hffff; f1 = f0 + 1;
        r0 = int'(qp >> 16); tq = qp & 16'hffff; r1 = r0 + 1;
        if (f0 >= 127) begin f0 = 127; f1 = 127; tf = 0; end
        if (r0 >= 7) begin r0 = 7; r1 = 7; tq = 0; end
        i00 = (r0 * 128 + f0) & 1023; i01 = (r0 * 128 + f1) & 1023;
        i10 = (r1 * 128 + f0) & 1023; i11 = (r1 * 128 + f1) & 1023;
        cut = int'(bilerp(tab_cut, i00, i01, i10, i11, tf, tq));
        fbg = int'(bilerp(tab_fb, i00, i01, i10, i11, tf, tq));
        gn  = int'(bilerp(tab_gain, i00, i01, i10, i11, tf, tq));
        v = sat32(longint'(it.smp) * 2);
        // soft clip the last pole into the feedback path
        y = ladder[3];
        if (y > 23726566) y = 23726566;
        if (y < -23726566) y = -23726566;
        y = y - mulq(cubic, mulq(mulq(y, y), y));
        hpin = sat32(mulq(fbg, y));
        fbh = one_pole_hp(fb_pole, int'(hpin), fbhp_x, fbhp_y);
        y0 = sat32(-longint'(v) - fbh);
        d = sat32(longint'(y0) - ladder[0] + ladder[1]);
        ladder[0] = sat32(ladder[0] + mulq(cut, d) * 2);
        d = sat32(longint'(ladder[0]) - 2 * longint'(ladder[1]) + ladder[2]);
        ladder[1] = sat32(ladder[1] + mulq(cut, d));
        d = sat32(longint'(ladder[1]) - 2 * longint'(ladder[2]) + ladder[3]);
        ladder[2] = sat32(ladder[2] + mulq(cut, d));
        d = sat32(longint'(ladder[2]) - 2 * longint'(ladder[3]));
        ladder[3] = sat32(ladder[3] + mulq(cut, d));
        v = sat32(mulq(gn, ladder[3]) * 2);
        dcout = one_pole_hp(dc_pole, v, dc_x, dc_y);
        v = sat32(mulq(nb0, dcout) + mulq(nb1, notch_hist[0]) + mulq(nb0, notch_hist[1])
                  + mulq(na1, notch_hist[2]) + mulq(na2, notch_hist[3]));
        notch_hist[1] = notch_hist[0];
        notch_hist[0] = dcout;
        notch_hist[3] = notch_hist[2];
        notch_hist[2] = v;
        y = (longint'(v) + 1) >>> 1;
        if (y > 8388607) begin y = 8388607; sat_seen = 1'b1; end
        if (y < -8388608) begin y = -8388608; sat_seen = 1'b1; end
        r.smp = y[23:0];
        r.sat = sat_seen;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 5);
        return $urandom_range(20, 150);
    endfunction

    // sample outputs, track handshakes and run the predictor
    always @(posedge aclk) begin
        filt_item_t it;
        filt_out_t  exp_out;
        s_fire <= s_valid && s_ready;
        if (!aresetn) begin
            q_pos = 13107; cubic = 2796203; fb_pole = 16450983; dc_pole = 16746480;
            nb0 = 16736766; nb1 = -33473530; na1 = 33473880; na2 = -16696315;
            ladder = '{default: 0}; notch_hist = '{default: 0};
            fbhp_x = 0; fbhp_y = 0; dc_x = 0; dc_y = 0;
        end else begin
            if (s_valid && s_ready || m_valid && m_ready || cfg_valid && cfg_ready)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_Q_POSITION:   q_pos = cfg_data[16:0];
                    CFG_SHAPER_CUBIC: cubic = cfg_data[24:0];
                    CFG_FB_HP_POLE:   fb_pole = cfg_data[24:0];
                    CFG_DC_POLE:      dc_pole = cfg_data[24:0];
                    CFG_NOTCH_B0:     nb0 = $signed(cfg_data);
                    CFG_NOTCH_B1:     nb1 = $signed(cfg_data);
                    CFG_NOTCH_A1:     na1 = $signed(cfg_data);
                    CFG_NOTCH_A2:     na2 = $signed(cfg_data);
                endcase
            end
            if (s_valid && s_ready) begin
                it.op = opcode_t'(s_opcode); it.smp = s_sample_in;
                it.fpos = s_freq_position; it.fmod = s_freq_mod;
                it.idx = s_entry_index; it.cut = s_entry_cutoff;
                it.fb = s_entry_feedback; it.gain = s_entry_gain;
                if (it.op == OP_TABLE) begin
                    tab_cut[it.idx] = it.cut;
                    tab_fb[it.idx] = it.fb;
                    tab_gain[it.idx] = it.gain;
                    table_writes++;
                end else begin
                    expected_samples.push_back(filter_sample(it));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: sample %0d sat %0b",
                                 m_sample_out, m_saturated);
                end else begin
                    exp_out = expected_samples.pop_front();
                    samples_checked++;
                    if (exp_out.smp !== m_sample_out || exp_out.sat !== m_saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %0d sat %0b, got %0d sat %0b",
                                     samples_checked, exp_out.smp, exp_out.sat,
                                     m_sample_out, m_saturated);
                    end
                end
            end
        end
    end

    // input driver: hold until accepted, then advance from the pending queue
    always @(negedge aclk) begin
        filt_item_t it;
        if (aresetn && !(s_valid && !s_fire)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                s_opcode <= it.op; s_sample_in <= it.smp;
                s_freq_position <= it.fpos; s_freq_mod <= it.fmod;
                s_entry_index <= it.idx; s_entry_cutoff <= it.cut;
                s_entry_feedback <= it.fb; s_entry_gain <= it.gain;
                s_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result stalls
    always @(negedge aclk) begin
        if (stall_cnt > 0) begin
            m_ready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end else begin
            m_ready <= aresetn;
            if ($urandom_range(0, 9) == 0) stall_cnt <= pick_gap();
        end
    end

    function automatic filt_item_t rand_item();
        filt_item_t it;
        it.op = OP_SAMPLE;
        it.smp = 24'($urandom);
        it.fpos = ($urandom_range(0, 9) == 0) ? 18'($urandom) : 18'($urandom_range(0, 70000));
        it.fmod = ($urandom_range(0, 9) == 0) ? 18'($urandom)
                                              : 18'(int'($urandom_range(0, 16000)) - 8000);
        it.idx = 10'($urandom);
        it.cut = $urandom;
        it.fb = $urandom;
        it.gain = $urandom;
        return it;
    endfunction

    // table entry with values that keep the ladder in a useful range
    function automatic filt_item_t table_item(int idx);
        filt_item_t it;
        it = rand_item();
        it.op = OP_TABLE;
        it.idx = 10'(idx);
        it.cut = $urandom_range(0, 7000000);
        it.fb = $urandom_range(0, 70000000);
        it.gain = $urandom_range(0, 40000000);
        return it;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_valid && expected_samples.size() == 0);
        // a trailing table write may still be in flight
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_all(logic [31:0] v[8]);
        for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), v[i]);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 12) pending_items.push_back(table_item($urandom));
            else pending_items.push_back(rand_item());
        end
    endtask

    initial begin
        filt_item_t it;
        logic [31:0] regs[8];
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // load the rows that the resonance settings below can reach: 0 to 2 and 7
        quiet = 1'b1;
        for (int r = 0; r < 8; r++) begin
            if (r < 3 || r == 7) begin
                for (int c = 0; c < 128; c++) pending_items.push_back(table_item(r * 128 + c));
            end
        end
        drain();
        quiet = 1'b0;

        // directed: field extremes and position corner cases
        it = rand_item();
        it.fpos = 0; it.fmod = 0; it.smp = 24'sh7fffff; pending_items.push_back(it);
        it.smp = 24'sh800000; pending_items.push_back(it);
        it.smp = 0; pending_items.push_back(it);
        it.fpos = 18'sh1ffff; it.fmod = 18'sh1ffff; pending_items.push_back(it);
        it.fpos = 18'sh20000; it.fmod = 18'sh20000; pending_items.push_back(it);
        it.fpos = 65536; it.fmod = 0; pending_items.push_back(it);
        it.fpos = 65535; it.fmod = 0; pending_items.push_back(it);
        it.fpos = 70000; it.fmod = -4464; pending_items.push_back(it);
        it.fpos = 516; it.fmod = 0; pending_items.push_back(it);
        it.fpos = -100; it.fmod = 50; pending_items.push_back(it);
        // extreme table contents, read back, then restored
        it = table_item(128);
        it.cut = 32'h7fffffff; it.fb = 32'h80000000; it.gain = 32'h7fffffff;
        pending_items.push_back(it);
        it.idx = 1023; it.cut = 32'h80000000; it.fb = 32'h7fffffff; it.gain = 32'h80000000;
        pending_items.push_back(it);
        it = table_item(0); it.cut = 0; it.fb = 0; it.gain = 0; pending_items.push_back(it);
        it = rand_item(); it.fpos = 0; it.fmod = 0; pending_items.push_back(it);
        pending_items.push_back(it);
        pending_items.push_back(table_item(128));
        pending_items.push_back(table_item(1023));
        random_phase(60);
        drain();

        // top extremes: full resonance, unit poles, notch b0 of one with the other notch terms zero
        regs = '{32'd65536, 32'd16777216, 32'd16777216, 32'd16777216,
                 32'd16777216, 32'd0, 32'd0, 32'd0};
        write_all(regs);
        it = rand_item(); it.fpos = 65536; it.fmod = 0; pending_items.push_back(it);
        random_phase(60);
        drain();

        // bottom extremes with set upper bits that the registers drop
        regs = '{32'hfffe0000, 32'hfe000000, 32'hfe000000, 32'hfe000000,
                 32'h0, 32'h0, 32'h0, 32'h0};
        write_all(regs);
        quiet = 1'b1;
        random_phase(50);
        drain();
        quiet = 1'b0;

        // resonance beyond one, mid-range values, most negative and most positive notch gains
        regs = '{32'd131071, 32'd8388608, 32'd12000000, 32'd16000000,
                 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
        write_all(regs);
        random_phase(30);
        drain();

        // random resonance within rows 0 to 2, random shaper, default poles and notch
        regs = '{$urandom_range(0, 18724), $urandom, 32'd16450983, 32'd16746480,
                 32'd16736766, -32'sd33473530, 32'd33473880, -32'sd16696315};
        write_all(regs);
        random_phase(60);
        drain();

        regs[0] = 13107; regs[1] = 2796203;
        write_all(regs);
        random_phase(60);
        drain();

        $display("checked %0d output samples and %0d table writes", samples_checked,
                 table_writes);
        $display("six register settings, %0d mismatches", mismatches);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: sim.f
design/dlf_pkg.sv
design/dlf_ram.sv
design/dlf_mul.sv
design/diode_ladder_filter.sv
verif/tb_top.sv
